@@ hdl/i2cms_pkg.sv @@
// shared types and constants of the i2c master transfer sequencer
package i2cms_pkg;

    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 5;
    localparam int LEN_W      = 6;
    localparam int TICK_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd65535;

    // controller status codes
    localparam logic [BYTE_W-1:0] SC_START        = 8'h08;
    localparam logic [BYTE_W-1:0] SC_RESTART      = 8'h10;
    localparam logic [BYTE_W-1:0] SC_SLAW_ACK     = 8'h18;
    localparam logic [BYTE_W-1:0] SC_SLAW_NACK    = 8'h20;
    localparam logic [BYTE_W-1:0] SC_DATA_TX_ACK  = 8'h28;
    localparam logic [BYTE_W-1:0] SC_DATA_TX_NACK = 8'h30;
    localparam logic [BYTE_W-1:0] SC_ARB_LOST     = 8'h38;
    localparam logic [BYTE_W-1:0] SC_SLAR_ACK     = 8'h40;
    localparam logic [BYTE_W-1:0] SC_SLAR_NACK    = 8'h48;
    localparam logic [BYTE_W-1:0] SC_DATA_RX_ACK  = 8'h50;
    localparam logic [BYTE_W-1:0] SC_DATA_RX_NACK = 8'h58;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TX = 3'd0,
        CMD_START   = 3'd1,
        CMD_STATUS  = 3'd2,
        CMD_TICK    = 3'd3,
        CMD_READ_RX = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        XS_IDLE      = 3'd0,
        XS_BUSY      = 3'd1,
        XS_NO_DATA   = 3'd2,
        XS_NACK_ADDR = 3'd3,
        XS_NACK_DATA = 3'd4,
        XS_ARB_LOST  = 3'd5,
        XS_TIMEOUT   = 3'd6,
        XS_OK        = 3'd7
    } t_xfer_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRITE_LEN = 2'd0,
        CFG_READ_LEN  = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } t_cfg_reg;

    // decoded result of one word, waiting for the buffer read data
    typedef struct packed {
        logic        write_data;
        logic        set_start;
        logic        clear_start;
        logic        set_stop;
        logic        set_ack;
        logic        clear_ack;
        logic        clear_interrupt;
        t_xfer_state xfer_state;
        logic        tx_sel;
        logic        rx_sel;
    } t_ctl;

endpackage

@@ hdl/i2cms_ram.sv @@
// generic single write port ram with registered read
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/i2cms_seq.sv @@
// transfer state, buffer indexes, timeout counter and status decode
module i2cms_seq
    import i2cms_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_acc,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [IDX_W-1:0]         i_index,
    input  logic [BYTE_W-1:0]        i_tx_byte,
    input  logic [BYTE_W-1:0]        i_status_code,
    input  logic [BYTE_W-1:0]        i_rx_data,
    output logic                     o_tx_we,
    output logic [$clog2(DEPTH)-1:0] o_tx_waddr,
    output logic [BYTE_W-1:0]        o_tx_wdata,
    output logic                     o_tx_re,
    output logic [$clog2(DEPTH)-1:0] o_tx_raddr,
    output logic                     o_rx_we,
    output logic [$clog2(DEPTH)-1:0] o_rx_waddr,
    output logic [BYTE_W-1:0]        o_rx_wdata,
    output logic                     o_rx_re,
    output logic [$clog2(DEPTH)-1:0] o_rx_raddr,
    output t_ctl                     o_ctl
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW  = ((CW > LEN_W) ? CW : LEN_W) + 1;
    localparam int IXW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [LEN_W-1:0]  r_write_len;
    logic [LEN_W-1:0]  r_read_len;
    logic [TICK_W-1:0] r_timeout;

    t_xfer_state       r_state, n_state;
    logic [CW-1:0]     r_wi, n_wi;
    logic [CW-1:0]     r_ri, n_ri;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [DEPTH-1:0]  r_rx_vld;

    t_cmd              cmd;
    logic              idx_ok;
    logic [CW-1:0]     wi_inc;
    logic [CW-1:0]     ri_inc;
    logic              wi_lt_wl;
    logic              ack_now;
    logic              ack_after;
    logic              timeout_hit;
    logic [CW-1:0]     tx_base;
    logic              store_rx;
    logic              wr;

    assign cmd         = t_cmd'(i_command);
    assign idx_ok      = IXW'(i_index) < IXW'(DEPTH);
    assign wi_inc      = (r_wi < DEPTH_C) ? r_wi + CW'(1) : r_wi;
    assign ri_inc      = (r_ri < DEPTH_C) ? r_ri + CW'(1) : r_ri;
    assign wi_lt_wl    = XW'(r_wi) < XW'(r_write_len);
    assign ack_now     = (XW'(r_ri) + XW'(1)) < XW'(r_read_len);
    assign ack_after   = (XW'(ri_inc) + XW'(1)) < XW'(r_read_len);
    assign timeout_hit = r_ticks >= r_timeout;
    assign tx_base     = (i_status_code == SC_START) ? '0 : r_wi;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_len <= '0;
            r_read_len  <= '0;
            r_timeout   <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_WRITE_LEN: r_write_len <= i_cfg_data[LEN_W-1:0];
                CFG_READ_LEN:  r_read_len  <= i_cfg_data[LEN_W-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_wi    = r_wi;
        n_ri    = r_ri;
        n_ticks = r_ticks;
        unique case (cmd)
            CMD_START: begin
                n_wi    = '0;
                n_ri    = '0;
                n_state = XS_BUSY;
            end
            CMD_STATUS: begin
                n_ticks = '0;
                unique case (i_status_code)
                    SC_START: n_wi = CW'(1);
                    SC_RESTART: begin
                        n_ri = '0;
                        n_wi = wi_inc;
                    end
                    SC_SLAW_ACK: begin
                        if (r_write_len == LEN_W'(1)) begin
                            n_state = XS_NO_DATA;
                        end else begin
                            n_wi = wi_inc;
                        end
                    end
                    SC_DATA_TX_ACK: begin
                        if (wi_lt_wl) begin
                            n_wi = wi_inc;
                        end else if (r_read_len == '0) begin
                            n_state = XS_OK;
                        end
                    end
                    SC_DATA_TX_NACK: n_state = XS_NACK_DATA;
                    SC_SLAR_ACK: ;
                    SC_DATA_RX_ACK: n_ri = ri_inc;
                    SC_DATA_RX_NACK: begin
                        n_ri    = ri_inc;
                        n_state = XS_OK;
                    end
                    SC_SLAW_NACK, SC_SLAR_NACK: n_state = XS_NACK_ADDR;
                    SC_ARB_LOST: n_state = XS_ARB_LOST;
                    default: n_state = XS_ARB_LOST;
                endcase
            end
            CMD_TICK: begin
                if (r_state == XS_BUSY) begin
                    if (timeout_hit) begin
                        n_state = XS_TIMEOUT;
                    end else begin
                        n_ticks = r_ticks + TICK_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // decoded controls
    always_comb begin
        o_ctl            = '0;
        o_ctl.xfer_state = n_state;
        wr               = 1'b0;
        store_rx         = 1'b0;
        unique case (cmd)
            CMD_START: o_ctl.set_start = 1'b1;
            CMD_STATUS: begin
                o_ctl.clear_interrupt = 1'b1;
                unique case (i_status_code)
                    SC_START, SC_RESTART: begin
                        wr                = 1'b1;
                        o_ctl.clear_start = 1'b1;
                    end
                    SC_SLAW_ACK: begin
                        if (r_write_len == LEN_W'(1)) begin
                            o_ctl.set_stop = 1'b1;
                        end else begin
                            wr = 1'b1;
                        end
                    end
                    SC_DATA_TX_ACK: begin
                        if (wi_lt_wl) begin
                            wr = 1'b1;
                        end else if (r_read_len != '0) begin
                            o_ctl.set_start = 1'b1;
                        end else begin
                            o_ctl.set_stop = 1'b1;
                        end
                    end
                    SC_SLAR_ACK: begin
                        o_ctl.set_ack   = ack_now;
                        o_ctl.clear_ack = !ack_now;
                    end
                    SC_DATA_RX_ACK: begin
                        store_rx        = 1'b1;
                        o_ctl.set_ack   = ack_after;
                        o_ctl.clear_ack = !ack_after;
                    end
                    SC_DATA_RX_NACK: begin
                        store_rx       = 1'b1;
                        o_ctl.set_stop = 1'b1;
                    end
                    SC_DATA_TX_NACK, SC_SLAW_NACK, SC_SLAR_NACK: o_ctl.set_stop = 1'b1;
                    default: ;
                endcase
                // leaving busy withdraws the start request
                if (r_state == XS_BUSY && n_state != XS_BUSY) begin
                    o_ctl.clear_start = 1'b1;
                end
            end
            CMD_TICK: begin
                o_ctl.clear_start = (r_state == XS_BUSY) && timeout_hit;
            end
            default: ;
        endcase
        o_ctl.write_data = wr;
        o_ctl.tx_sel     = wr && (tx_base < DEPTH_C);
        o_ctl.rx_sel     = (cmd == CMD_READ_RX) && idx_ok && r_rx_vld[AW'(i_index)];
        o_tx_re          = i_acc && wr;
        o_tx_raddr       = AW'(tx_base);
        o_rx_we          = i_acc && store_rx && (r_ri < DEPTH_C);
        o_rx_waddr       = AW'(r_ri);
        o_rx_wdata       = i_rx_data;
        o_rx_re          = i_acc && (cmd == CMD_READ_RX) && idx_ok;
        o_rx_raddr       = AW'(i_index);
        o_tx_we          = i_acc && (cmd == CMD_LOAD_TX) && idx_ok;
        o_tx_waddr       = AW'(i_index);
        o_tx_wdata       = i_tx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= XS_IDLE;
            r_wi     <= '0;
            r_ri     <= '0;
            r_ticks  <= '0;
            r_rx_vld <= '0;
        end else if (i_acc) begin
            r_state <= n_state;
            r_wi    <= n_wi;
            r_ri    <= n_ri;
            r_ticks <= n_ticks;
            if (o_rx_we) begin
                r_rx_vld[o_rx_waddr] <= 1'b1;
            end
        end
    end

endmodule

@@ hdl/i2c_master_transfer_sequencer_top.sv @@
// top level of the i2c master transfer sequencer
// a result word passes through the decode stage register and then the result register
// throughput: one word per cycle while the receiver does not stall, set by the single
// buffer read per word in the decode stage and the registered read of the buffer rams
// reset: synchronous active low; clears transfer state, indexes, timeout count,
// receive valid bits and pipeline valids; the transmit buffer is not cleared
module i2c_master_transfer_sequencer_top
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input word channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [BYTE_W-1:0]     i_tx_byte,
    input  logic [BYTE_W-1:0]     i_status_code,
    input  logic [BYTE_W-1:0]     i_rx_data,
    // result word channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BYTE_W-1:0]     o_tx_data,
    output logic                  o_write_data,
    output logic                  o_set_start,
    output logic                  o_clear_start,
    output logic                  o_set_stop,
    output logic                  o_set_ack,
    output logic                  o_clear_ack,
    output logic                  o_clear_interrupt,
    output logic [2:0]            o_transfer_state,
    output logic [BYTE_W-1:0]     o_rx_byte_out
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    // buffer ram ports driven by the decoder
    logic              tx_we, tx_re, rx_we, rx_re;
    logic [AW-1:0]     tx_waddr, tx_raddr, rx_waddr, rx_raddr;
    logic [BYTE_W-1:0] tx_wdata, rx_wdata;
    logic [BYTE_W-1:0] tx_q, rx_q;
    t_ctl              dec_ctl;

    // decode stage register and result register
    logic              r_s1_vld;
    t_ctl              r_s1_ctl;
    logic              r_o_vld;
    t_ctl              r_o_ctl;
    logic [BYTE_W-1:0] r_o_tx_data;
    logic [BYTE_W-1:0] r_o_rx_byte;

    logic              in_acc;
    logic              s1_adv;

    // the decode stage moves on whenever the result register is free or being taken
    assign s1_adv  = !r_o_vld || !i_stall;
    assign o_stall = r_s1_vld && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    // state update happens at accept, the buffer read data lands in the next cycle
    i2cms_seq #(
        .DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_acc         (in_acc),
        .i_command     (i_command),
        .i_index       (i_index),
        .i_tx_byte     (i_tx_byte),
        .i_status_code (i_status_code),
        .i_rx_data     (i_rx_data),
        .o_tx_we       (tx_we),
        .o_tx_waddr    (tx_waddr),
        .o_tx_wdata    (tx_wdata),
        .o_tx_re       (tx_re),
        .o_tx_raddr    (tx_raddr),
        .o_rx_we       (rx_we),
        .o_rx_waddr    (rx_waddr),
        .o_rx_wdata    (rx_wdata),
        .o_rx_re       (rx_re),
        .o_rx_raddr    (rx_raddr),
        .o_ctl         (dec_ctl)
    );

    // transmit buffer, loaded by the host, read as bytes go out
    i2cms_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (tx_wdata),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_q)
    );

    // receive buffer, unwritten entries read as zero through the valid bits
    i2cms_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_wdata),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_q)
    );

    // ram read data stays put while the decode stage holds, since no read is issued then
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctl <= dec_ctl;
        end
        if (s1_adv && r_s1_vld) begin
            r_o_ctl     <= r_s1_ctl;
            r_o_tx_data <= r_s1_ctl.tx_sel ? tx_q : '0;
            r_o_rx_byte <= r_s1_ctl.rx_sel ? rx_q : '0;
        end
    end

    assign o_valid           = r_o_vld;
    assign o_tx_data         = r_o_tx_data;
    assign o_write_data      = r_o_ctl.write_data;
    assign o_set_start       = r_o_ctl.set_start;
    assign o_clear_start     = r_o_ctl.clear_start;
    assign o_set_stop        = r_o_ctl.set_stop;
    assign o_set_ack         = r_o_ctl.set_ack;
    assign o_clear_ack       = r_o_ctl.clear_ack;
    assign o_clear_interrupt = r_o_ctl.clear_interrupt;
    assign o_transfer_state  = r_o_ctl.xfer_state;
    assign o_rx_byte_out     = r_o_rx_byte;

`ifndef SYNTHESIS
    // an accepted word always occupies the decode stage next cycle
    a_acc_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted word lost before decode stage");

    // a held decode stage keeps its word
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> r_s1_vld)
        else $error("decode stage dropped a held word");

    // ack and nack are never asked together
    a_ack_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_set_ack && o_clear_ack))
        else $error("ack and nack both requested");

    // a transmit byte and a receive byte never share a result word
    a_tx_rx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_data) |-> (o_rx_byte_out == '0))
        else $error("receive byte reported with a transmit byte");

    // withdrawing start without sending a byte only happens at transfer end
    a_stop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clear_start && !o_write_data) |-> (o_transfer_state != XS_BUSY))
        else $error("start withdrawn while transfer still busy");
`endif

endmodule

@@ bench/i2c_master_transfer_sequencer_top_tb.sv @@
// testbench of the i2c master transfer sequencer: directed and random words checked by a predictor
module i2c_master_transfer_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    localparam int DEPTH        = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1700;
    localparam int PHASE_WORDS  = 140;
    localparam int SETTLE       = 4;     // margin past the decode stage and result register
    localparam int IDLE_PCT     = 20;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [CMD_W-1:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_UNUSED_HI = 3'd7;
    localparam logic [BYTE_W-1:0] SC_UNKNOWN    = 8'hFF;
    localparam logic [TICK_W-1:0] TIMEOUT_MAX   = 24'hFF_FFFF;

    // one input word
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] txb;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] rxd;
    } t_word;

    // controller actions of one result word
    typedef struct packed {
        logic [BYTE_W-1:0] tx_data;
        logic              write_data;
        logic              set_start;
        logic              clear_start;
        logic              set_stop;
        logic              set_ack;
        logic              clear_ack;
        logic              clear_interrupt;
        logic [2:0]        xfer_state;
        logic [BYTE_W-1:0] rx_out;
    } t_actions;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [CMD_W-1:0]      i_command;
    logic [IDX_W-1:0]      i_index;
    logic [BYTE_W-1:0]     i_tx_byte;
    logic [BYTE_W-1:0]     i_status_code;
    logic [BYTE_W-1:0]     i_rx_data;
    logic                  o_valid;
    logic                  i_stall;
    logic [BYTE_W-1:0]     o_tx_data;
    logic                  o_write_data;
    logic                  o_set_start;
    logic                  o_clear_start;
    logic                  o_set_stop;
    logic                  o_set_ack;
    logic                  o_clear_ack;
    logic                  o_clear_interrupt;
    logic [2:0]            o_transfer_state;
    logic [BYTE_W-1:0]     o_rx_byte_out;

    i2c_master_transfer_sequencer_top #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (.*);

    // shadow of the sequencer state and its registers
    logic [BYTE_W-1:0] tx_shadow [DEPTH];
    logic [BYTE_W-1:0] rx_shadow [DEPTH];
    int unsigned       tx_ptr;
    int unsigned       rx_ptr;
    t_xfer_state       xfer;
    logic [TICK_W-1:0] quiet_ticks;
    logic [LEN_W-1:0]  wr_len;
    logic [LEN_W-1:0]  rd_len;
    logic [TICK_W-1:0] tmo_limit;

    t_actions due_actions[$];   // controller actions still owed by the block
    int       words_sent;
    int       mismatch_count;
    int       cycle_count;
    bit       tx_quiet;         // sender offers a word every cycle
    bit       rx_quiet;         // receiver does not stall but for a requested hold-off
    int       hold_req;         // requested receiver hold-off, in cycles

    t_actions got_act;
    t_actions want_act;

    // clock, 20 ns period
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // hard stop if the run hangs
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // next transmit byte; positions past the buffer end send zero
    function automatic logic [BYTE_W-1:0] take_tx_byte();
        logic [BYTE_W-1:0] b;
        b = '0;
        if (tx_ptr < DEPTH) begin
            b = tx_shadow[tx_ptr];
            tx_ptr++;
        end
        return b;
    endfunction

    // received bytes past the buffer end are dropped
    function automatic void keep_rx_byte(logic [BYTE_W-1:0] v);
        if (rx_ptr < DEPTH) begin
            rx_shadow[rx_ptr] = v;
            rx_ptr++;
        end
    endfunction

    // advance the shadow by one accepted word and return what the block must answer
    function automatic t_actions sequencer_step(t_word w);
        t_actions act;
        logic     was_busy;
        act = '0;
        case (w.cmd)
            CMD_LOAD_TX: tx_shadow[w.idx] = w.txb;
            CMD_START: begin
                rx_ptr = 0;
                tx_ptr = 0;
                act.set_start = 1'b1;
                xfer = XS_BUSY;
            end
            CMD_STATUS: begin
                was_busy = (xfer == XS_BUSY);
                quiet_ticks = '0;
                act.clear_interrupt = 1'b1;
                case (w.code)
                    SC_START, SC_RESTART: begin
                        if (w.code == SC_START) tx_ptr = 0;
                        else rx_ptr = 0;
                        act.tx_data = take_tx_byte();
                        act.write_data = 1'b1;
                        act.clear_start = 1'b1;
                    end
                    SC_SLAW_ACK: begin
                        if (wr_len == 1) begin
                            act.set_stop = 1'b1;
                            xfer = XS_NO_DATA;
                        end else begin
                            act.tx_data = take_tx_byte();
                            act.write_data = 1'b1;
                        end
                    end
                    SC_DATA_TX_ACK: begin
                        if (tx_ptr < wr_len) begin
                            act.tx_data = take_tx_byte();
                            act.write_data = 1'b1;
                        end else if (rd_len != 0) begin
                            act.set_start = 1'b1;   // repeated start for the read part
                        end else begin
                            act.set_stop = 1'b1;
                            xfer = XS_OK;
                        end
                    end
                    SC_DATA_TX_NACK: begin
                        act.set_stop = 1'b1;
                        xfer = XS_NACK_DATA;
                    end
                    SC_SLAR_ACK, SC_DATA_RX_ACK: begin
                        if (w.code == SC_DATA_RX_ACK) keep_rx_byte(w.rxd);
                        // nack goes out on the last byte
                        if (rx_ptr + 1 < rd_len) act.set_ack = 1'b1;
                        else act.clear_ack = 1'b1;
                    end
                    SC_DATA_RX_NACK: begin
                        keep_rx_byte(w.rxd);
                        act.set_stop = 1'b1;
                        xfer = XS_OK;
                    end
                    SC_SLAW_NACK, SC_SLAR_NACK: begin
                        act.set_stop = 1'b1;
                        xfer = XS_NACK_ADDR;
                    end
                    default: xfer = XS_ARB_LOST;
                endcase
                // leaving busy always withdraws the start request
                if (was_busy && xfer != XS_BUSY) act.clear_start = 1'b1;
            end
            CMD_TICK: begin
                if (xfer == XS_BUSY) begin
                    if (quiet_ticks >= tmo_limit) begin
                        xfer = XS_TIMEOUT;
                        act.clear_start = 1'b1;
                    end else begin
                        quiet_ticks = quiet_ticks + 1'b1;
                    end
                end
            end
            CMD_READ_RX: act.rx_out = rx_shadow[w.idx];
            default: ;
        endcase
        act.xfer_state = xfer;
        return act;
    endfunction

    // offer one word, with random gaps before it, and record what it must cause
    task automatic send_word(input t_word w);
        while (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= w.cmd;
        i_index       <= w.idx;
        i_tx_byte     <= w.txb;
        i_status_code <= w.code;
        i_rx_data     <= w.rxd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        due_actions.push_back(sequencer_step(w));
        words_sent++;
        @(negedge i_clk);
    endtask

    // status event; the unused fields carry random values
    task automatic do_status(input logic [BYTE_W-1:0] code);
        t_word w;
        w.cmd  = CMD_STATUS;
        w.idx  = $urandom_range(DEPTH - 1);
        w.txb  = $urandom_range(255);
        w.code = code;
        w.rxd  = $urandom_range(255);
        send_word(w);
    endtask

    // any other command
    task automatic do_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic [BYTE_W-1:0] txb);
        t_word w;
        w.cmd  = cmd;
        w.idx  = idx;
        w.txb  = txb;
        w.code = $urandom_range(255);
        w.rxd  = $urandom_range(255);
        send_word(w);
    endtask

    // sender pause: drop valid until every owed word is back, then let the pipe settle
    task automatic wait_results();
        i_valid <= 1'b0;
        while (due_actions.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // register write, only while the block is idle
    task automatic set_register(input t_cfg_reg which, input logic [CFG_DATA_W-1:0] value);
        wait_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= which;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (which)
            CFG_WRITE_LEN: wr_len = value[LEN_W-1:0];
            CFG_READ_LEN:  rd_len = value[LEN_W-1:0];
            CFG_TIMEOUT:   tmo_limit = value[TICK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // receiver: random stalls, a quiet mode and a long counted hold-off
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    // every accepted result word against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_act.tx_data         = o_tx_data;
            got_act.write_data      = o_write_data;
            got_act.set_start       = o_set_start;
            got_act.clear_start     = o_clear_start;
            got_act.set_stop        = o_set_stop;
            got_act.set_ack         = o_set_ack;
            got_act.clear_ack       = o_clear_ack;
            got_act.clear_interrupt = o_clear_interrupt;
            got_act.xfer_state      = o_transfer_state;
            got_act.rx_out          = o_rx_byte_out;
            if (due_actions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result word with nothing owed: %h", got_act);
            end else begin
                want_act = due_actions.pop_front();
                check_field("tx_data", want_act.tx_data, got_act.tx_data);
                check_field("write_data", want_act.write_data, got_act.write_data);
                check_field("set_start", want_act.set_start, got_act.set_start);
                check_field("clear_start", want_act.clear_start, got_act.clear_start);
                check_field("set_stop", want_act.set_stop, got_act.set_stop);
                check_field("set_ack", want_act.set_ack, got_act.set_ack);
                check_field("clear_ack", want_act.clear_ack, got_act.clear_ack);
                check_field("clear_interrupt", want_act.clear_interrupt,
                            got_act.clear_interrupt);
                check_field("transfer_state", want_act.xfer_state, got_act.xfer_state);
                check_field("rx_byte_out", want_act.rx_out, got_act.rx_out);
            end
        end
    end

    // random interruption inside a transfer: ticks, a bus error or a stray word
    task automatic disturb(output bit ended);
        int    r;
        int    n;
        t_word w;
        ended = 1'b0;
        r = $urandom_range(99);
        if (r < 6) begin
            // long bursts run into the timeout when the limit is small
            if ($urandom_range(3) == 0 && tmo_limit < 40) n = tmo_limit + 2;
            else n = $urandom_range(1, 3);
            repeat (n) do_cmd(CMD_TICK, $urandom_range(DEPTH - 1), $urandom_range(255));
        end else if (r < 9) begin
            case ($urandom_range(4))
                0: do_status(SC_SLAW_NACK);
                1: do_status(SC_DATA_TX_NACK);
                2: do_status(SC_SLAR_NACK);
                3: do_status(SC_ARB_LOST);
                default: do_status($urandom_range(255));
            endcase
            ended = 1'b1;
        end else if (r < 11) begin
            w.cmd  = $urandom_range(7);
            w.idx  = $urandom_range(DEPTH - 1);
            w.txb  = $urandom_range(255);
            w.code = $urandom_range(255);
            w.rxd  = $urandom_range(255);
            send_word(w);
        end
    endtask

    // one well-formed transfer for the current lengths, with random disturbances
    task automatic run_transfer();
        bit ended;
        int n_rx;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4))
                do_cmd(CMD_LOAD_TX, $urandom_range(DEPTH - 1), $urandom_range(255));
        do_cmd(CMD_START, $urandom_range(DEPTH - 1), $urandom_range(255));
        disturb(ended);
        if (ended) return;
        do_status(SC_START);
        do_status(SC_SLAW_ACK);
        if (wr_len != 1) begin
            // now and then keep acking the address to run off the buffer end
            if ($urandom_range(15) == 0) repeat ($urandom_range(30, 34)) do_status(SC_SLAW_ACK);
            while (tx_ptr < wr_len) begin
                disturb(ended);
                if (ended) return;
                do_status(SC_DATA_TX_ACK);
            end
            do_status(SC_DATA_TX_ACK);
            if (rd_len != 0) begin
                do_status(SC_RESTART);
                do_status(SC_SLAR_ACK);
                if ($urandom_range(15) == 0) n_rx = $urandom_range(30, 36);
                else n_rx = rd_len - 1;
                repeat (n_rx) begin
                    disturb(ended);
                    if (ended) return;
                    do_status(SC_DATA_RX_ACK);
                end
                do_status(SC_DATA_RX_NACK);
            end
        end
        repeat ($urandom_range(0, 3))
            do_cmd(CMD_READ_RX, $urandom_range(DEPTH - 1), $urandom_range(255));
    endtask

    // idle block: empty receive buffer, ticks and unused commands do nothing
    task automatic test_idle_behavior();
        do_cmd(CMD_READ_RX, '0, 8'h00);
        do_cmd(CMD_READ_RX, DEPTH - 1, 8'hFF);
        do_cmd(CMD_TICK, '0, 8'h00);
        do_cmd(CMD_UNUSED_LO, DEPTH - 1, 8'hFF);
        do_cmd(CMD_UNUSED_HI, '0, 8'h00);
    endtask

    // fill the whole transmit buffer so no unwritten entry is ever sent
    task automatic test_load_buffer();
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) do_cmd(CMD_LOAD_TX, i, 8'h00);
            else if (i == 1) do_cmd(CMD_LOAD_TX, i, 8'hFF);
            else do_cmd(CMD_LOAD_TX, i, $urandom_range(255));
        end
    endtask

    // address plus two data bytes, then stop
    task automatic test_write_transfer();
        set_register(CFG_WRITE_LEN, 3);
        set_register(CFG_READ_LEN, 0);
        do_cmd(CMD_START, '0, '0);
        do_status(SC_START);
        do_status(SC_SLAW_ACK);
        do_status(SC_DATA_TX_ACK);
        do_status(SC_DATA_TX_ACK);
    endtask

    // write part, repeated start, two bytes read back
    task automatic test_write_read_transfer();
        set_register(CFG_WRITE_LEN, 2);
        set_register(CFG_READ_LEN, 2);
        do_cmd(CMD_START, '0, '0);
        do_status(SC_START);
        do_status(SC_SLAW_ACK);
        do_status(SC_DATA_TX_ACK);
        do_status(SC_RESTART);
        do_status(SC_SLAR_ACK);
        do_status(SC_DATA_RX_ACK);
        do_status(SC_DATA_RX_NACK);
        do_cmd(CMD_READ_RX, 0, '0);
        do_cmd(CMD_READ_RX, 1, '0);
    endtask

    // no data, nack on address and data, lost arbitration, unknown code, event with no transfer running
    task automatic test_error_codes();
        set_register(CFG_WRITE_LEN, 1);
        do_cmd(CMD_START, '0, '0);
        do_status(SC_START);
        do_status(SC_SLAW_ACK);
        do_cmd(CMD_START, '0, '0);
        do_status(SC_SLAW_NACK);
        do_cmd(CMD_START, '0, '0);
        do_status(SC_DATA_TX_NACK);
        do_cmd(CMD_START, '0, '0);
        do_status(SC_SLAR_NACK);
        do_cmd(CMD_START, '0, '0);
        do_status(SC_ARB_LOST);
        do_cmd(CMD_START, '0, '0);
        do_status(SC_UNKNOWN);
        do_status(SC_DATA_TX_ACK);
    endtask

    // timeout at limit zero, and a count cleared by a status event
    task automatic test_timeout();
        set_register(CFG_TIMEOUT, '0);
        do_cmd(CMD_START, '0, '0);
        do_cmd(CMD_TICK, '0, '0);
        do_cmd(CMD_TICK, '0, '0);
        set_register(CFG_TIMEOUT, 2);
        do_cmd(CMD_START, '0, '0);
        repeat (2) do_cmd(CMD_TICK, '0, '0);
        do_status(SC_START);
        repeat (3) do_cmd(CMD_TICK, '0, '0);
    endtask

    // receiver holds off while the sender keeps offering, so the block fills and stalls
    task automatic test_backpressure();
        set_register(CFG_WRITE_LEN, 8);
        set_register(CFG_READ_LEN, 8);
        set_register(CFG_TIMEOUT, TIMEOUT_RESET);
        tx_quiet = 1'b1;
        hold_req = HOLD_CYCLES;
        repeat (3) run_transfer();
        tx_quiet = 1'b0;
        wait_results();
    endtask

    // phases of random transfers, each with its own register settings
    task automatic test_random_transfers();
        int                    phase;
        int                    first_word;
        int                    phase_word;
        logic [CFG_DATA_W-1:0] wl;
        logic [CFG_DATA_W-1:0] rl;
        logic [CFG_DATA_W-1:0] tmo;
        phase = 0;
        first_word = words_sent;
        while (words_sent - first_word < RANDOM_WORDS) begin
            case (phase)
                0: begin wl = 32; rl = 32; tmo = TIMEOUT_MAX; end
                1: begin wl = 0;  rl = 0;  tmo = '0; end
                2: begin wl = 1;  rl = $urandom_range(1, 4); tmo = 1; end
                default: begin
                    if ($urandom_range(9) == 0) wl = $urandom_range(32);
                    else wl = $urandom_range(1, 6);
                    if ($urandom_range(9) == 0) rl = $urandom_range(32);
                    else rl = $urandom_range(0, 5);
                    case ($urandom_range(4))
                        0: tmo = '0;
                        1: tmo = $urandom_range(1, 8);
                        2: tmo = $urandom_range(9, 40);
                        3: tmo = TIMEOUT_RESET;
                        default: tmo = TIMEOUT_MAX;
                    endcase
                end
            endcase
            set_register(CFG_WRITE_LEN, wl);
            set_register(CFG_READ_LEN, rl);
            set_register(CFG_TIMEOUT, tmo);
            // one phase runs at full rate on both sides
            tx_quiet = (phase == 3);
            rx_quiet = (phase == 3);
            phase_word = words_sent;
            while (words_sent - phase_word < PHASE_WORDS) run_transfer();
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
            phase++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_command     = '0;
        i_index       = '0;
        i_tx_byte     = '0;
        i_status_code = '0;
        i_rx_data     = '0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        hold_req      = 0;
        words_sent     = 0;
        mismatch_count = 0;
        // shadow state after reset
        for (int i = 0; i < DEPTH; i++) begin
            tx_shadow[i] = '0;
            rx_shadow[i] = '0;
        end
        tx_ptr      = 0;
        rx_ptr      = 0;
        xfer        = XS_IDLE;
        quiet_ticks = '0;
        wr_len      = '0;
        rd_len      = '0;
        tmo_limit   = TIMEOUT_RESET;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_behavior();
        test_load_buffer();
        test_write_transfer();
        test_write_read_transfer();
        test_error_codes();
        test_timeout();
        test_backpressure();
        test_random_transfers();

        wait_results();
        repeat (4 * SETTLE) @(negedge i_clk);
        if (mismatch_count == 0 && due_actions.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
